FILE: rtl/matrix_scale_extract_top_assert.svh
// Assertion macros shared by the RTL of the scale extraction block.
// Each macro takes a label, an antecedent and a consequent, and it samples on clk
// with rst_n as the disable.
`ifndef MATRIX_SCALE_EXTRACT_TOP_ASSERT_SVH
`define MATRIX_SCALE_EXTRACT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define MSE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matrix_scale_extract: same-cycle check failed");
`define MSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matrix_scale_extract: next-cycle check failed");
`else
`define MSE_ASSERT_SAME(label, ante, cons)
`define MSE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/mse_pkg.sv
package mse_pkg;

  localparam int UNIT_BITS  = 29;
  localparam int LEN_W      = 32;
  localparam int RES_W      = 34;
  localparam int UNIT_W     = 31;
  localparam int Q_W        = 30;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 30;
  localparam int AXIS_LAT   = SQRT_STEPS + 2 + DIV_STEPS;
  localparam int REJ_LAT    = 4;

  typedef logic [2:0][RES_W-1:0]  res_vec_t;
  typedef logic [2:0][UNIT_W-1:0] unit_vec_t;

  typedef struct packed {
    logic signed [31:0] col0_x;
    logic signed [31:0] col0_y;
    logic signed [31:0] col0_z;
    logic signed [31:0] col1_x;
    logic signed [31:0] col1_y;
    logic signed [31:0] col1_z;
    logic signed [31:0] col2_x;
    logic signed [31:0] col2_y;
    logic signed [31:0] col2_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic               degenerate;
  } out_t;

endpackage

FILE: rtl/mse_axis.sv
// Length and unit direction of one vector: squares, saturating sum, a bit-per-stage
// square root and three bit-per-stage dividers.
module mse_axis
  import mse_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  res_vec_t         vec_in,
  output logic [LEN_W-1:0] len_out,
  output unit_vec_t        unit_out
);

  localparam int MAG_DLY = SQRT_STEPS + 2;

  logic [2:0][LEN_W-1:0] mag;
  logic [2:0]            sgn;
  logic [2:0][63:0]      sq_r;
  logic [2:0][LEN_W-1:0] mag_dly_r [MAG_DLY];
  logic [2:0]            sgn_dly_r [AXIS_LAT];
  logic [65:0]           sum_full;
  logic [63:0]           x_r [SQRT_STEPS+1];
  logic [63:0]           r_r [SQRT_STEPS+1];
  logic [63:0]           x_nxt [SQRT_STEPS];
  logic [63:0]           r_nxt [SQRT_STEPS];
  logic [2:0][LEN_W-1:0] rem_r [DIV_STEPS];
  logic [2:0][Q_W-1:0]   q_r [DIV_STEPS];
  logic [LEN_W-1:0]      dlen_r [DIV_STEPS];
  logic [2:0][LEN_W-1:0] rem_nxt [DIV_STEPS];
  logic [2:0][Q_W-1:0]   q_nxt [DIV_STEPS];
  logic [LEN_W-1:0]      dlen_in [DIV_STEPS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sgn[i] = vec_in[i][RES_W-1];
      mag[i] = sgn[i] ? LEN_W'(-$signed(vec_in[i])) : vec_in[i][LEN_W-1:0];
    end
    sum_full = 66'(sq_r[0]) + 66'(sq_r[1]) + 66'(sq_r[2]);
  end

  always_comb begin
    logic [63:0] sbit;
    logic [63:0] trial;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      sbit  = 64'd1 << (62 - 2 * k);
      trial = r_r[k] + sbit;
      if (x_r[k] >= trial) begin
        x_nxt[k] = x_r[k] - trial;
        r_nxt[k] = (r_r[k] >> 1) + sbit;
      end else begin
        x_nxt[k] = x_r[k];
        r_nxt[k] = r_r[k] >> 1;
      end
    end
  end

  always_comb begin
    logic [LEN_W:0] t;
    logic           ge;
    for (int j = 0; j < DIV_STEPS; j++) begin
      dlen_in[j] = (j == 0) ? r_r[SQRT_STEPS][LEN_W-1:0] : dlen_r[(j == 0) ? 0 : j - 1];
      for (int i = 0; i < 3; i++) begin
        if (j == 0) begin
          t = {1'b0, mag_dly_r[MAG_DLY-1][i]};
        end else begin
          t = {rem_r[j-1][i], 1'b0};
        end
        ge = t >= {1'b0, dlen_in[j]};
        rem_nxt[j][i] = ge ? LEN_W'(t - {1'b0, dlen_in[j]}) : t[LEN_W-1:0];
        if (j == 0) begin
          q_nxt[j][i] = {{(Q_W-1){1'b0}}, ge};
        end else begin
          q_nxt[j][i] = {q_r[j-1][i][Q_W-2:0], ge};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 64'(mag[i]) * 64'(mag[i]);
      end
      mag_dly_r[0] <= mag;
      for (int n = 1; n < MAG_DLY; n++) begin
        mag_dly_r[n] <= mag_dly_r[n-1];
      end
      sgn_dly_r[0] <= sgn;
      for (int n = 1; n < AXIS_LAT; n++) begin
        sgn_dly_r[n] <= sgn_dly_r[n-1];
      end
      x_r[0] <= (|sum_full[65:64]) ? '1 : sum_full[63:0];
      r_r[0] <= '0;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        x_r[k+1] <= x_nxt[k];
        r_r[k+1] <= r_nxt[k];
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        rem_r[j]  <= rem_nxt[j];
        q_r[j]    <= q_nxt[j];
        dlen_r[j] <= dlen_in[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sgn_dly_r[AXIS_LAT-1][i]) begin
        unit_out[i] = UNIT_W'(-{1'b0, q_r[DIV_STEPS-1][i]});
      end else begin
        unit_out[i] = {1'b0, q_r[DIV_STEPS-1][i]};
      end
    end
  end

  assign len_out = dlen_r[DIV_STEPS-1];

endmodule

FILE: rtl/mse_reject.sv
// Removes from a vector its component along a unit direction, in four stages.
module mse_reject
  import mse_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  res_vec_t  v_in,
  input  unit_vec_t u_in,
  output res_vec_t  v_out
);

  localparam logic signed [63:0] RND     = (64'sd1 <<< UNIT_BITS) - 64'sd1;
  localparam logic signed [35:0] RES_MAX = 36'sd4294967295;

  logic signed [64:0] prod [3];
  logic signed [63:0] p_r [3];
  logic signed [63:0] dot;
  logic signed [63:0] dot_adj;
  logic signed [34:0] d_r;
  logic signed [65:0] eprod [3];
  logic signed [63:0] e_r [3];
  res_vec_t           v_d1_r, v_d2_r, v_d3_r;
  unit_vec_t          u_d1_r, u_d2_r;
  res_vec_t           out_r;
  res_vec_t           out_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i]  = 65'($signed(u_in[i])) * 65'($signed(v_in[i]));
      eprod[i] = 66'(d_r) * 66'($signed(u_d2_r[i]));
    end
    dot     = p_r[0] + p_r[1] + p_r[2];
    dot_adj = dot[63] ? dot + RND : dot;
  end

  always_comb begin
    logic signed [63:0] e_adj;
    logic signed [35:0] f;
    logic signed [35:0] diff;
    for (int i = 0; i < 3; i++) begin
      e_adj = e_r[i][63] ? e_r[i] + RND : e_r[i];
      f     = 36'(e_adj >>> UNIT_BITS);
      diff  = 36'($signed(v_d3_r[i])) - f;
      if (diff > RES_MAX) begin
        out_nxt[i] = RES_W'(RES_MAX);
      end else if (diff < -RES_MAX) begin
        out_nxt[i] = RES_W'(-RES_MAX);
      end else begin
        out_nxt[i] = RES_W'(diff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= prod[i][63:0];
        e_r[i] <= eprod[i][63:0];
      end
      d_r    <= 35'(dot_adj >>> UNIT_BITS);
      v_d1_r <= v_in;
      v_d2_r <= v_d1_r;
      v_d3_r <= v_d2_r;
      u_d1_r <= u_in;
      u_d2_r <= u_d1_r;
      out_r  <= out_nxt;
    end
  end

  assign v_out = out_r;

endmodule

FILE: rtl/matrix_scale_extract_top.sv
// Per-axis scale extraction of a 3x3 matrix by Gram-Schmidt, fully pipelined.
// Throughput: one matrix beat per cycle while the output is not stalled; the whole pipeline advances together.
// The depth is set mostly by three serial length/normalize passes of 64 stages each.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers keep data.
`include "matrix_scale_extract_top_assert.svh"

module matrix_scale_extract_top
  import mse_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Stage numbers are counted from the input register, which is stage 0.
  localparam int A_LAT    = AXIS_LAT;
  localparam int S_STAGE  = 3 * A_LAT + 2 * REJ_LAT;
  localparam int DEPTH    = S_STAGE + 6;
  localparam int C12_DLY  = A_LAT;
  localparam int C2A_DLY  = A_LAT;
  localparam int U1_DLY   = A_LAT + REJ_LAT;
  localparam int U0_DLY   = S_STAGE + 2 - A_LAT;
  localparam int LEN0_DLY = S_STAGE + 4 - A_LAT;
  localparam int LEN1_DLY = S_STAGE + 4 - (2 * A_LAT + REJ_LAT);
  localparam int LEN2_DLY = 4;

  localparam logic signed [62:0] RND = (63'sd1 <<< UNIT_BITS) - 63'sd1;

  // The whole pipeline moves when the output register is empty or being drained.
  logic             en;
  logic [DEPTH-1:0] vld_r;
  in_t              in_r;

  res_vec_t         c0_ext, c1_ext, c2_ext;
  res_vec_t         c1_dly_r [C12_DLY];
  res_vec_t         c2_dly_r [C12_DLY];
  res_vec_t         c2a_dly_r [C2A_DLY];
  unit_vec_t        u1_dly_r [U1_DLY];
  unit_vec_t        u0_dly_r [U0_DLY];
  logic [LEN_W-1:0] len0_dly_r [LEN0_DLY];
  logic [LEN_W-1:0] len1_dly_r [LEN1_DLY];
  logic [LEN_W-1:0] len2_dly_r [LEN2_DLY];

  logic [LEN_W-1:0] len0, len1, len2;
  unit_vec_t        u0, u1, u2;
  res_vec_t         c1_res, c2_res_a, c2_res_b;

  logic signed [61:0] cr_p_r [6];
  logic signed [61:0] cr_p_nxt [6];
  logic signed [31:0] w_r [3];
  logic signed [31:0] w_nxt [3];
  logic signed [63:0] tq_r [3];
  logic signed [63:0] tq_nxt [3];
  logic signed [63:0] tsum;
  logic               tneg_r;
  out_t               out_r;
  out_t               out_nxt;

  function automatic logic signed [61:0] umul(input logic signed [UNIT_W-1:0] a,
                                              input logic signed [UNIT_W-1:0] b);
    return 62'(a) * 62'(b);
  endfunction

  // Cross term difference, truncated toward zero after dropping the unit scale.
  function automatic logic signed [31:0] cross_term(input logic signed [61:0] a,
                                                    input logic signed [61:0] b);
    logic signed [62:0] diff;
    logic signed [62:0] adj;
    diff = 63'(a) - 63'(b);
    adj  = diff[62] ? diff + RND : diff;
    return 32'(adj >>> UNIT_BITS);
  endfunction

  function automatic logic [31:0] sat_len(input logic [LEN_W-1:0] l);
    return l[31] ? 32'h7FFF_FFFF : l;
  endfunction

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[DEPTH-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_comb begin
    c0_ext[0] = RES_W'(in_r.col0_x);
    c0_ext[1] = RES_W'(in_r.col0_y);
    c0_ext[2] = RES_W'(in_r.col0_z);
    c1_ext[0] = RES_W'(in_r.col1_x);
    c1_ext[1] = RES_W'(in_r.col1_y);
    c1_ext[2] = RES_W'(in_r.col1_z);
    c2_ext[0] = RES_W'(in_r.col2_x);
    c2_ext[1] = RES_W'(in_r.col2_y);
    c2_ext[2] = RES_W'(in_r.col2_z);
  end

  // Column 0 gives scale_x and the first direction. Columns 1 and 2 wait for it.
  mse_axis u_axis0 (
    .clk      (clk),
    .en       (en),
    .vec_in   (c0_ext),
    .len_out  (len0),
    .unit_out (u0)
  );

  mse_reject u_rej_c1 (
    .clk   (clk),
    .en    (en),
    .v_in  (c1_dly_r[C12_DLY-1]),
    .u_in  (u0),
    .v_out (c1_res)
  );

  // Column 2 loses its first projection in parallel with column 1.
  mse_reject u_rej_c2a (
    .clk   (clk),
    .en    (en),
    .v_in  (c2_dly_r[C12_DLY-1]),
    .u_in  (u0),
    .v_out (c2_res_a)
  );

  mse_axis u_axis1 (
    .clk      (clk),
    .en       (en),
    .vec_in   (c1_res),
    .len_out  (len1),
    .unit_out (u1)
  );

  mse_reject u_rej_c2b (
    .clk   (clk),
    .en    (en),
    .v_in  (c2a_dly_r[C2A_DLY-1]),
    .u_in  (u1),
    .v_out (c2_res_b)
  );

  mse_axis u_axis2 (
    .clk      (clk),
    .en       (en),
    .vec_in   (c2_res_b),
    .len_out  (len2),
    .unit_out (u2)
  );

  // Handedness: w = u1 x u2 in unit scale, then the sign of u0 . w.
  always_comb begin
    cr_p_nxt[0] = umul(u1_dly_r[U1_DLY-1][1], u2[2]);
    cr_p_nxt[1] = umul(u1_dly_r[U1_DLY-1][2], u2[1]);
    cr_p_nxt[2] = umul(u1_dly_r[U1_DLY-1][2], u2[0]);
    cr_p_nxt[3] = umul(u1_dly_r[U1_DLY-1][0], u2[2]);
    cr_p_nxt[4] = umul(u1_dly_r[U1_DLY-1][0], u2[1]);
    cr_p_nxt[5] = umul(u1_dly_r[U1_DLY-1][1], u2[0]);
    w_nxt[0]    = cross_term(cr_p_r[0], cr_p_r[1]);
    w_nxt[1]    = cross_term(cr_p_r[2], cr_p_r[3]);
    w_nxt[2]    = cross_term(cr_p_r[4], cr_p_r[5]);
    for (int i = 0; i < 3; i++) begin
      tq_nxt[i] = 64'($signed(u0_dly_r[U0_DLY-1][i])) * 64'(w_r[i]);
    end
    tsum = tq_r[0] + tq_r[1] + tq_r[2];
  end

  // A zero length zeroes every later scale and suppresses the sign flip.
  always_comb begin
    logic        z0, z1, z2, flip;
    logic [31:0] s0, s1, s2;
    z0   = len0_dly_r[LEN0_DLY-1] == '0;
    z1   = len1_dly_r[LEN1_DLY-1] == '0;
    z2   = len2_dly_r[LEN2_DLY-1] == '0;
    s0   = sat_len(len0_dly_r[LEN0_DLY-1]);
    s1   = z0 ? '0 : sat_len(len1_dly_r[LEN1_DLY-1]);
    s2   = (z0 || z1) ? '0 : sat_len(len2_dly_r[LEN2_DLY-1]);
    flip = !(z0 || z1 || z2) && tneg_r;
    out_nxt.scale_x    = flip ? -s0 : s0;
    out_nxt.scale_y    = flip ? -s1 : s1;
    out_nxt.scale_z    = flip ? -s2 : s2;
    out_nxt.degenerate = z0 || z1 || z2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_data;
      c1_dly_r[0]   <= c1_ext;
      c2_dly_r[0]   <= c2_ext;
      c2a_dly_r[0]  <= c2_res_a;
      u1_dly_r[0]   <= u1;
      u0_dly_r[0]   <= u0;
      len0_dly_r[0] <= len0;
      len1_dly_r[0] <= len1;
      len2_dly_r[0] <= len2;
      for (int n = 1; n < C12_DLY; n++) begin
        c1_dly_r[n] <= c1_dly_r[n-1];
        c2_dly_r[n] <= c2_dly_r[n-1];
      end
      for (int n = 1; n < C2A_DLY; n++) begin
        c2a_dly_r[n] <= c2a_dly_r[n-1];
      end
      for (int n = 1; n < U1_DLY; n++) begin
        u1_dly_r[n] <= u1_dly_r[n-1];
      end
      for (int n = 1; n < U0_DLY; n++) begin
        u0_dly_r[n] <= u0_dly_r[n-1];
      end
      for (int n = 1; n < LEN0_DLY; n++) begin
        len0_dly_r[n] <= len0_dly_r[n-1];
      end
      for (int n = 1; n < LEN1_DLY; n++) begin
        len1_dly_r[n] <= len1_dly_r[n-1];
      end
      for (int n = 1; n < LEN2_DLY; n++) begin
        len2_dly_r[n] <= len2_dly_r[n-1];
      end
      for (int i = 0; i < 6; i++) begin
        cr_p_r[i] <= cr_p_nxt[i];
      end
      for (int i = 0; i < 3; i++) begin
        w_r[i]  <= w_nxt[i];
        tq_r[i] <= tq_nxt[i];
      end
      tneg_r <= tsum[63];
      out_r  <= out_nxt;
    end
  end

  // A stalled cycle must not move any beat through the pipeline.
  `MSE_ASSERT_NEXT(a_stall_holds_valids, !en, $stable(vld_r))
  // The last scale is always zero once a length has collapsed.
  `MSE_ASSERT_SAME(a_degen_zero_z, out_valid && out_data.degenerate, out_data.scale_z == 0)
  // No sign flip is applied to a degenerate basis.
  `MSE_ASSERT_SAME(a_degen_no_flip, out_valid && out_data.degenerate, !out_data.scale_x[31])
  // A good basis has a nonzero first length.
  `MSE_ASSERT_SAME(a_good_nonzero_x, out_valid && !out_data.degenerate, out_data.scale_x != 0)

endmodule

FILE: tb/matrix_scale_extract_top_tb.sv
module matrix_scale_extract_top_tb
  import mse_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef longint vec3_t [3];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Traffic shaping: percentage of cycles in which the sender idles and the
  // receiver stalls, plus a count of cycles for a long receiver hold-off.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;

  out_t scale_queue[$];
  int   error_count = 0;
  int   sent_count = 0;
  int   checked_count = 0;
  int   degenerate_count = 0;
  int   flipped_count = 0;

  matrix_scale_extract_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // Integer square root, floor, by the classic bit-pair method.
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Length of a vector; the sum of squares saturates at all ones.
  function automatic longint unsigned vec_length(vec3_t v);
    longint unsigned s;
    longint unsigned m;
    longint unsigned sq;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? longint'(-v[i]) : v[i];
      sq = m * m;
      s = s + sq;
      if (s < sq) s = '1;
    end
    return int_sqrt(s);
  endfunction

  // Unit vector in Q1.29, each magnitude truncated and clamped to one.
  function automatic void to_unit(vec3_t v, longint unsigned len, output vec3_t u);
    longint unsigned m;
    longint unsigned q;
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? longint'(-v[i]) : v[i];
      q = (m << UNIT_BITS) / len;
      if (q > (64'd1 << UNIT_BITS)) q = 64'd1 << UNIT_BITS;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  // Removes the component of v along the unit vector u; the residual is
  // clamped to plus or minus (2^32 - 1).
  function automatic void remove_along(inout vec3_t v, input vec3_t u);
    longint one;
    longint d;
    longint r;
    one = longint'(1) << UNIT_BITS;
    d = (u[0] * v[0] + u[1] * v[1] + u[2] * v[2]) / one;
    for (int i = 0; i < 3; i++) begin
      r = v[i] - (d * u[i]) / one;
      if (r > 64'sd4294967295) r = 64'sd4294967295;
      if (r < -64'sd4294967295) r = -64'sd4294967295;
      v[i] = r;
    end
  endfunction

  function automatic logic signed [31:0] clip32(longint x);
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    return x[31:0];
  endfunction

  // Expected scales and degenerate flag of one matrix.
  function automatic out_t predict_scales(in_t m);
    vec3_t c0, c1, c2, u0, u1, u2;
    longint s[3];
    longint unsigned len;
    longint one;
    longint wx, wy, wz, t;
    out_t r;
    one = longint'(1) << UNIT_BITS;
    c0 = '{longint'(m.col0_x), longint'(m.col0_y), longint'(m.col0_z)};
    c1 = '{longint'(m.col1_x), longint'(m.col1_y), longint'(m.col1_z)};
    c2 = '{longint'(m.col2_x), longint'(m.col2_y), longint'(m.col2_z)};
    s = '{0, 0, 0};
    r.degenerate = 1'b0;
    len = vec_length(c0);
    s[0] = longint'(len);
    if (len == 0) begin
      r.degenerate = 1'b1;
    end else begin
      to_unit(c0, len, u0);
      remove_along(c1, u0);
      len = vec_length(c1);
      s[1] = longint'(len);
      if (len == 0) begin
        r.degenerate = 1'b1;
      end else begin
        to_unit(c1, len, u1);
        remove_along(c2, u0);
        remove_along(c2, u1);
        len = vec_length(c2);
        s[2] = longint'(len);
        if (len == 0) begin
          r.degenerate = 1'b1;
        end else begin
          to_unit(c2, len, u2);
          wx = (u1[1] * u2[2] - u1[2] * u2[1]) / one;
          wy = (u1[2] * u2[0] - u1[0] * u2[2]) / one;
          wz = (u1[0] * u2[1] - u1[1] * u2[0]) / one;
          t = u0[0] * wx + u0[1] * wy + u0[2] * wz;
          // A left-handed basis negates every scale after saturation.
          if (t < 0) begin
            for (int i = 0; i < 3; i++) begin
              if (s[i] > 64'sd2147483647) s[i] = 64'sd2147483647;
              s[i] = -s[i];
            end
          end
        end
      end
    end
    r.scale_x = clip32(s[0]);
    r.scale_y = clip32(s[1]);
    r.scale_z = clip32(s[2]);
    return r;
  endfunction

  // Sends one matrix beat. The task is entered and left at a falling edge.
  // Before the beat the sender may idle, which drops valid for whole cycles.
  task automatic send_matrix(in_t m);
    out_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = m;
    do @(posedge clk); while (!in_ready);
    e = predict_scales(m);
    scale_queue.push_back(e);
    sent_count++;
    if (e.degenerate) degenerate_count++;
    if (e.scale_x[31]) flipped_count++;
    @(negedge clk);
  endtask

  function automatic in_t make_matrix(int a0, int a1, int a2, int b0, int b1, int b2,
                                      int c0, int c1, int c2);
    in_t m;
    m.col0_x = a0; m.col0_y = a1; m.col0_z = a2;
    m.col1_x = b0; m.col1_y = b1; m.col1_z = b2;
    m.col2_x = c0; m.col2_y = c1; m.col2_z = c2;
    return m;
  endfunction

  function automatic int rand_small(int unsigned k);
    return int'($urandom_range(2 * k)) - int'(k);
  endfunction

  // Random matrix: mostly well-formed bases of moderate size, with raw
  // random bits, zero columns and dependent columns mixed in.
  function automatic in_t random_matrix();
    in_t m;
    int unsigned k;
    int unsigned pick;
    int f;
    pick = $urandom_range(99);
    k = 1 << $urandom_range(4, 30);
    m = make_matrix(rand_small(k), rand_small(k), rand_small(k),
                    rand_small(k), rand_small(k), rand_small(k),
                    rand_small(k), rand_small(k), rand_small(k));
    if (pick < 20) begin
      m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    end else if (pick < 27) begin
      m.col0_x = 0; m.col0_y = 0; m.col0_z = 0;
    end else if (pick < 34) begin
      // Column 1 is a multiple of column 0, possibly nudged a little.
      f = rand_small(3);
      m.col1_x = m.col0_x * f + rand_small(1);
      m.col1_y = m.col0_y * f;
      m.col1_z = m.col0_z * f;
    end else if (pick < 41) begin
      // Column 2 lies in the plane of the first two.
      m.col2_x = m.col0_x + m.col1_x;
      m.col2_y = m.col0_y + m.col1_y;
      m.col2_z = m.col0_z + m.col1_z;
    end
    return m;
  endfunction

  // Receiver: stalls at random, or holds off for a counted stretch.
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checks each result beat against the oldest expectation.
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (scale_queue.size() == 0) begin
        $error("result beat with no matrix outstanding: %p", out_data);
        error_count++;
      end else begin
        e = scale_queue.pop_front();
        checked_count++;
        if (out_data.scale_x !== e.scale_x) begin
          $error("scale_x expected %0d got %0d", e.scale_x, out_data.scale_x);
          error_count++;
        end
        if (out_data.scale_y !== e.scale_y) begin
          $error("scale_y expected %0d got %0d", e.scale_y, out_data.scale_y);
          error_count++;
        end
        if (out_data.scale_z !== e.scale_z) begin
          $error("scale_z expected %0d got %0d", e.scale_z, out_data.scale_z);
          error_count++;
        end
        if (out_data.degenerate !== e.degenerate) begin
          $error("degenerate expected %0b got %0b", e.degenerate, out_data.degenerate);
          error_count++;
        end
      end
    end
  end

  // Extremes and the named corner cases: zero columns, dependent columns,
  // left-handed bases, near-parallel residuals and oversize lengths.
  task automatic test_corner_matrices();
    int one;
    int mx;
    int mn;
    one = 1 << 16;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(one, 0, 0, 0, one, 0, 0, 0, one));
    send_matrix(make_matrix(one, 0, 0, 0, one, 0, 0, 0, -one));
    send_matrix(make_matrix(0, one, 0, one, 0, 0, 0, 0, one));
    send_matrix(make_matrix(2 * one, 0, 0, 0, 3 * one, 0, 0, 0, 4 * one));
    send_matrix(make_matrix(0, 0, 0, one, 2, 3, 4, 5, 6));
    send_matrix(make_matrix(one, one, 0, 2 * one, 2 * one, 0, 0, 0, one));
    send_matrix(make_matrix(one, 0, 0, 0, one, 0, one, one, 0));
    send_matrix(make_matrix(one, 0, 0, 0, one, 0, 0, 0, 0));
    send_matrix(make_matrix(one, 0, 0, one, 1, 0, 0, 0, one));
    send_matrix(make_matrix(one, one, one, one, one, one + 1, 1, 0, 0));
    send_matrix(make_matrix(mx, mx, mx, mx, mn, 0, 0, mx, mn));
    send_matrix(make_matrix(mn, mn, mn, mx, 0, mn, mn, mx, 0));
    send_matrix(make_matrix(mx, 0, 0, 0, mx, 0, 0, 0, mx));
    send_matrix(make_matrix(mn, 0, 0, 0, mn, 0, 0, 0, mn));
    send_matrix(make_matrix(mx, 0, 0, 0, mx, 0, 0, 0, mn));
    send_matrix(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_matrix(make_matrix(-1, -1, -1, 1, -1, 0, 1, 1, -2));
    send_matrix(make_matrix(mx, mx, mx, mn, mn, mn, 1, -1, 0));
    send_matrix(make_matrix(-one, 0, 0, 0, -one, 0, 0, 0, -one));
  endtask

  // Random matrices under one sender idling and receiver stall setting.
  task automatic test_random_stream(int unsigned n, int unsigned idle, int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_matrix(random_matrix());
  endtask

  // The receiver stops for much longer than the pipeline depth while the
  // sender keeps offering beats, so the block has to stall its input.
  task automatic test_output_holdoff();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 3 * 206;
    repeat (250) send_matrix(random_matrix());
  endtask

  initial begin
    @(negedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_corner_matrices();
    test_random_stream(160, 29, 53);
    test_random_stream(160, 53, 29);
    test_random_stream(160, 0, 0);
    test_output_holdoff();
    in_valid = 1'b0;
    recv_stall_pct = 0;
    while (scale_queue.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    $display("Sent %0d matrices, checked %0d results: %0d degenerate, %0d with negated scale_x.",
             sent_count, checked_count, degenerate_count, flipped_count);
    $display("Corner cases, three idling mixes and a long output hold-off were run.");
    if (error_count == 0 && scale_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10ms;
    $display("Timed out with %0d results outstanding.", scale_queue.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
